### design/pbp_pkg.sv
// Shared types, codes and helpers of the page buffer pool slot manager.
package pbp_pkg;

   localparam int DEF_NUM_SLOTS = 32;
   localparam int IDX_W = 6;
   localparam logic [IDX_W-1:0] NONE_IDX = '1;

   typedef enum logic [2:0] {
      KIND_GET        = 3'd0,
      KIND_ALLOC      = 3'd1,
      KIND_DIRTY      = 3'd2,
      KIND_UNPIN      = 3'd3,
      KIND_FLUSH_FILE = 3'd4,
      KIND_FLUSH_PAGE = 3'd5,
      KIND_CLEAR      = 3'd6,
      KIND_NOP        = 3'd7
   } kind_type;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
   localparam logic [2:0] ST_NO_SLOT      = 3'd2;
   localparam logic [2:0] ST_PINNED       = 3'd3;
   localparam logic [2:0] ST_RESIDENT     = 3'd4;
   localparam logic [2:0] ST_NOT_PINNED   = 3'd5;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_TAG  = 2'd1;
   localparam logic [1:0] SRC_REQ  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE       = 5'd0,
      OP_LOAD       = 5'd1,
      OP_LOOKUP     = 5'd2,
      OP_EMIT       = 5'd3,
      OP_PIN_INC    = 5'd4,
      OP_PIN_DEC    = 5'd5,
      OP_SET_DIRTY  = 5'd6,
      OP_CLR_DIRTY  = 5'd7,
      OP_U1         = 5'd8,
      OP_U2         = 5'd9,
      OP_L1         = 5'd10,
      OP_L2         = 5'd11,
      OP_F1         = 5'd12,
      OP_TAKE_FREE  = 5'd13,
      OP_VIC_START  = 5'd14,
      OP_VIC_STEP   = 5'd15,
      OP_EVICT      = 5'd16,
      OP_FILL       = 5'd17,
      OP_WALK_START = 5'd18,
      OP_WALK_FETCH = 5'd19,
      OP_WALK_ADV   = 5'd20
   } op_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] act;
      logic       slot_en;
      logic [1:0] src;
      logic       last;
   } emit_type;

   typedef struct packed {
      op_type   op;
      emit_type em;
   } cmd_type;

   typedef struct packed {
      logic     hit;
      logic     pinned;
      logic     pin_one;
      logic     dirty;
      logic     dirty_res;
      logic     cur_valid;
      logic     free_valid;
      logic     guard_done;
      logic     file_match;
      logic     multi;
      logic     out_free;
      kind_type kind;
   } stat_type;

   function automatic emit_type mk_emit(logic [2:0] status, logic [1:0] act,
                                        logic slot_en, logic [1:0] src, logic last);
      emit_type e;
      e.status  = status;
      e.act     = act;
      e.slot_en = slot_en;
      e.src     = src;
      e.last    = last;
      return e;
   endfunction

endpackage

### design/pbp_ctrl.sv
// Request sequencer: one-hot state machine issuing datapath commands.
module pbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pbp_pkg::stat_type  stat,
   output pbp_pkg::cmd_type   cmd
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_LOOK  = 16'h0002,
      S_DISP  = 16'h0004,
      S_EMIT  = 16'h0008,
      S_U1    = 16'h0010,
      S_U2    = 16'h0020,
      S_L1    = 16'h0040,
      S_L2    = 16'h0080,
      S_FILL  = 16'h0100,
      S_VSCAN = 16'h0200,
      S_EVICT = 16'h0400,
      S_WTEST = 16'h0800,
      S_WDEC  = 16'h1000,
      S_WCLR  = 16'h2000,
      S_F1    = 16'h4000,
      S_WADV  = 16'h8000
   } state_type;

   state_type         state_ff, state_in, ret_ff, ret_in;
   pbp_pkg::emit_type em_ff, em_in;
   logic              emit_go;
   pbp_pkg::emit_type emit_d;
   state_type         emit_ret;
   logic              walk;

   assign req_stall = (state_ff != S_IDLE);
   assign walk = (stat.kind == pbp_pkg::KIND_FLUSH_FILE) || (stat.kind == pbp_pkg::KIND_CLEAR);

   always_comb begin
      state_in = state_ff;
      em_in    = em_ff;
      ret_in   = ret_ff;
      cmd.op   = pbp_pkg::OP_NONE;
      cmd.em   = em_ff;
      emit_go  = 1'b0;
      emit_d   = pbp_pkg::mk_emit(pbp_pkg::ST_OK, pbp_pkg::ACT_NONE, 1'b0,
                                  pbp_pkg::SRC_ZERO, 1'b1);
      emit_ret = S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pbp_pkg::OP_LOAD;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.op   = pbp_pkg::OP_LOOKUP;
            state_in = S_DISP;
         end
         S_DISP: begin
            case (stat.kind)
               pbp_pkg::KIND_GET, pbp_pkg::KIND_ALLOC: begin
                  if (stat.hit && stat.kind == pbp_pkg::KIND_ALLOC) begin
                     emit_go = 1'b1;
                     emit_d.status = pbp_pkg::ST_RESIDENT;
                  end else if (stat.hit) begin
                     if (stat.pinned && !stat.multi) begin
                        emit_go = 1'b1;
                        emit_d.status = pbp_pkg::ST_PINNED;
                     end else begin
                        cmd.op   = pbp_pkg::OP_PIN_INC;
                        state_in = S_U1;
                     end
                  end else if (stat.free_valid) begin
                     cmd.op   = pbp_pkg::OP_TAKE_FREE;
                     state_in = S_L1;
                  end else begin
                     cmd.op   = pbp_pkg::OP_VIC_START;
                     state_in = S_VSCAN;
                  end
               end
               pbp_pkg::KIND_DIRTY: begin
                  if (!stat.hit) begin
                     emit_go = 1'b1;
                     emit_d.status = pbp_pkg::ST_NOT_RESIDENT;
                  end else begin
                     cmd.op   = pbp_pkg::OP_SET_DIRTY;
                     state_in = S_U1;
                  end
               end
               pbp_pkg::KIND_UNPIN: begin
                  if (!stat.hit) begin
                     emit_go = 1'b1;
                     emit_d.status = pbp_pkg::ST_NOT_RESIDENT;
                  end else if (!stat.pinned) begin
                     emit_go = 1'b1;
                     emit_d.status = pbp_pkg::ST_NOT_PINNED;
                  end else begin
                     cmd.op = pbp_pkg::OP_PIN_DEC;
                     if (stat.pin_one) begin
                        state_in = S_U1;
                     end else begin
                        emit_go = 1'b1;
                        emit_d.slot_en = 1'b1;
                     end
                  end
               end
               pbp_pkg::KIND_FLUSH_PAGE: begin
                  if (!stat.hit) begin
                     emit_go = 1'b1;
                     emit_d.status = pbp_pkg::ST_NOT_RESIDENT;
                  end else if (stat.dirty) begin
                     cmd.op  = pbp_pkg::OP_CLR_DIRTY;
                     emit_go = 1'b1;
                     emit_d  = pbp_pkg::mk_emit(pbp_pkg::ST_OK, pbp_pkg::ACT_WRITE, 1'b1,
                                                pbp_pkg::SRC_REQ, 1'b1);
                  end else begin
                     emit_go = 1'b1;
                     emit_d.slot_en = 1'b1;
                  end
               end
               pbp_pkg::KIND_FLUSH_FILE, pbp_pkg::KIND_CLEAR: begin
                  cmd.op   = pbp_pkg::OP_WALK_START;
                  state_in = S_WTEST;
               end
               default: begin
                  emit_go = 1'b1;
               end
            endcase
         end
         S_EMIT: begin
            cmd.op = pbp_pkg::OP_EMIT;
            if (stat.out_free) begin
               state_in = em_ff.last ? S_IDLE : ret_ff;
            end
         end
         S_U1: begin
            cmd.op   = pbp_pkg::OP_U1;
            state_in = S_U2;
         end
         S_U2: begin
            cmd.op   = pbp_pkg::OP_U2;
            state_in = walk ? S_F1 : S_L1;
         end
         S_L1: begin
            cmd.op   = pbp_pkg::OP_L1;
            state_in = S_L2;
         end
         S_L2: begin
            cmd.op = pbp_pkg::OP_L2;
            if ((stat.kind == pbp_pkg::KIND_GET || stat.kind == pbp_pkg::KIND_ALLOC)
                && !stat.hit) begin
               state_in = S_FILL;
            end else begin
               emit_go = 1'b1;
               emit_d.slot_en = 1'b1;
            end
         end
         S_FILL: begin
            cmd.op  = pbp_pkg::OP_FILL;
            emit_go = 1'b1;
            emit_d.slot_en = 1'b1;
            if (stat.kind == pbp_pkg::KIND_GET) begin
               emit_d.act = pbp_pkg::ACT_READ;
               emit_d.src = pbp_pkg::SRC_REQ;
            end
         end
         S_VSCAN: begin
            if (stat.cur_valid && !stat.pinned) begin
               if (stat.dirty_res) begin
                  emit_go  = 1'b1;
                  emit_d   = pbp_pkg::mk_emit(pbp_pkg::ST_OK, pbp_pkg::ACT_WRITE, 1'b1,
                                              pbp_pkg::SRC_TAG, 1'b0);
                  emit_ret = S_EVICT;
               end else begin
                  state_in = S_EVICT;
               end
            end else if (stat.guard_done || !stat.cur_valid) begin
               emit_go = 1'b1;
               emit_d.status = pbp_pkg::ST_NO_SLOT;
            end else begin
               cmd.op = pbp_pkg::OP_VIC_STEP;
            end
         end
         S_EVICT, S_WCLR: begin
            cmd.op   = pbp_pkg::OP_EVICT;
            state_in = S_U1;
         end
         S_WTEST: begin
            if (!stat.cur_valid || stat.guard_done) begin
               emit_go = 1'b1;
            end else begin
               cmd.op   = pbp_pkg::OP_WALK_FETCH;
               state_in = S_WDEC;
            end
         end
         S_WDEC: begin
            if (!stat.pinned && (stat.kind == pbp_pkg::KIND_CLEAR || stat.file_match)) begin
               if (stat.kind == pbp_pkg::KIND_FLUSH_FILE && stat.dirty) begin
                  emit_go  = 1'b1;
                  emit_d   = pbp_pkg::mk_emit(pbp_pkg::ST_OK, pbp_pkg::ACT_WRITE, 1'b1,
                                              pbp_pkg::SRC_TAG, 1'b0);
                  emit_ret = S_WCLR;
               end else begin
                  state_in = S_WCLR;
               end
            end else begin
               state_in = S_WADV;
            end
         end
         S_F1: begin
            cmd.op   = pbp_pkg::OP_F1;
            state_in = S_WADV;
         end
         S_WADV: begin
            cmd.op   = pbp_pkg::OP_WALK_ADV;
            state_in = S_WTEST;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (emit_go) begin
         state_in = S_EMIT;
         em_in    = emit_d;
         ret_in   = emit_ret;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
      em_ff <= em_in;
   end

endmodule

### design/pbp_datapath.sv
// Slot tables, list links, walk pointers and the result register.
module pbp_datapath #(
   parameter int NUM_SLOTS = pbp_pkg::DEF_NUM_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_kind,
   input  logic [15:0]       req_file_id,
   input  logic [23:0]       req_page_number,
   input  logic              req_allow_multi_pin,
   input  pbp_pkg::cmd_type  cmd,
   output pbp_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [4:0]        rsp_slot_index,
   output logic [1:0]        rsp_host_action,
   output logic [15:0]       rsp_action_file,
   output logic [23:0]       rsp_action_page,
   output logic              rsp_last_result
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int IW = pbp_pkg::IDX_W;
   localparam logic [IW-1:0] NUM_IDX = IW'(NUM_SLOTS);
   localparam logic [IW-1:0] NONE = pbp_pkg::NONE_IDX;

   logic [15:0]   tag_file_ff [NUM_SLOTS];
   logic [23:0]   tag_page_ff [NUM_SLOTS];
   logic          res_ff      [NUM_SLOTS];
   logic          dirty_ff    [NUM_SLOTS];
   logic [7:0]    pin_ff      [NUM_SLOTS];
   logic [IW-1:0] prev_ff     [NUM_SLOTS];
   logic [IW-1:0] next_ff     [NUM_SLOTS];

   pbp_pkg::kind_type kind_ff, kind_in;
   logic [15:0]   file_ff, file_in;
   logic [23:0]   page_ff, page_in;
   logic          multi_ff, multi_in, hit_ff, hit_in;
   logic [IW-1:0] cur_ff, cur_in, pv_ff, pv_in, nx_ff, nx_in, wnx_ff, wnx_in;
   logic [IW-1:0] guard_ff, guard_in, head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] free_ff, free_in;
   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_status_ff, out_status_in;
   logic [4:0]    out_slot_ff, out_slot_in;
   logic [1:0]    out_act_ff, out_act_in;
   logic [15:0]   out_file_ff, out_file_in;
   logic [23:0]   out_page_ff, out_page_in;
   logic          out_last_ff, out_last_in;

   logic [SW-1:0] cs;
   logic          hit_c, out_free, ld_out;
   logic [IW-1:0] hit_idx_c;
   logic          nx_we, pv_we;
   logic [SW-1:0] nx_wa, pv_wa;
   logic [IW-1:0] nx_wd, pv_wd;

   function automatic logic ok_idx(logic [IW-1:0] x);
      return x < NUM_IDX;
   endfunction

   assign cs       = cur_ff[SW-1:0];
   assign out_free = !out_valid_ff || !rsp_stall;
   assign ld_out   = (cmd.op == pbp_pkg::OP_EMIT) && out_free;

   // tag match across all slots, lowest index wins
   always_comb begin
      hit_c     = 1'b0;
      hit_idx_c = NONE;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (res_ff[i] && tag_file_ff[i] == file_ff && tag_page_ff[i] == page_ff) begin
            hit_c     = 1'b1;
            hit_idx_c = IW'(i);
         end
      end
   end

   always_comb begin
      stat.hit        = hit_ff;
      stat.pinned     = pin_ff[cs] != 8'd0;
      stat.pin_one    = pin_ff[cs] == 8'd1;
      stat.dirty      = dirty_ff[cs];
      stat.dirty_res  = dirty_ff[cs] && res_ff[cs];
      stat.cur_valid  = ok_idx(cur_ff);
      stat.free_valid = ok_idx(free_ff);
      stat.guard_done = guard_ff == NUM_IDX;
      stat.file_match = res_ff[cs] && tag_file_ff[cs] == file_ff;
      stat.multi      = multi_ff;
      stat.out_free   = out_free;
      stat.kind       = kind_ff;
   end

   // link write ports: one address per array per cycle
   always_comb begin
      nx_we = 1'b0;
      nx_wa = cs;
      nx_wd = NONE;
      pv_we = 1'b0;
      pv_wa = cs;
      pv_wd = NONE;
      case (cmd.op)
         pbp_pkg::OP_U2: begin
            nx_we = ok_idx(pv_ff);
            nx_wa = pv_ff[SW-1:0];
            nx_wd = nx_ff;
            pv_we = ok_idx(nx_ff);
            pv_wa = nx_ff[SW-1:0];
            pv_wd = pv_ff;
         end
         pbp_pkg::OP_L1: begin
            nx_we = 1'b1;
            nx_wd = head_ff;
            pv_we = 1'b1;
         end
         pbp_pkg::OP_L2: begin
            pv_we = ok_idx(head_ff);
            pv_wa = head_ff[SW-1:0];
            pv_wd = cur_ff;
         end
         pbp_pkg::OP_F1: begin
            nx_we = 1'b1;
            nx_wd = free_ff;
            pv_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      kind_in  = kind_ff;
      file_in  = file_ff;
      page_in  = page_ff;
      multi_in = multi_ff;
      hit_in   = hit_ff;
      cur_in   = cur_ff;
      pv_in    = pv_ff;
      nx_in    = nx_ff;
      wnx_in   = wnx_ff;
      guard_in = guard_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      case (cmd.op)
         pbp_pkg::OP_LOAD: begin
            kind_in  = pbp_pkg::kind_type'(req_kind);
            file_in  = req_file_id;
            page_in  = req_page_number;
            multi_in = req_allow_multi_pin;
         end
         pbp_pkg::OP_LOOKUP: begin
            hit_in = hit_c;
            cur_in = hit_idx_c;
         end
         pbp_pkg::OP_U1: begin
            pv_in = prev_ff[cs];
            nx_in = next_ff[cs];
            if (head_ff == cur_ff) head_in = next_ff[cs];
            if (tail_ff == cur_ff) tail_in = prev_ff[cs];
         end
         pbp_pkg::OP_L2: begin
            head_in = cur_ff;
            if (!ok_idx(tail_ff)) tail_in = cur_ff;
         end
         pbp_pkg::OP_F1: begin
            free_in = cur_ff;
         end
         pbp_pkg::OP_TAKE_FREE: begin
            cur_in  = free_ff;
            free_in = next_ff[free_ff[SW-1:0]];
         end
         pbp_pkg::OP_VIC_START: begin
            cur_in   = tail_ff;
            guard_in = '0;
         end
         pbp_pkg::OP_VIC_STEP: begin
            cur_in   = prev_ff[cs];
            guard_in = guard_ff + IW'(1);
         end
         pbp_pkg::OP_WALK_START: begin
            cur_in   = head_ff;
            guard_in = '0;
         end
         pbp_pkg::OP_WALK_FETCH: begin
            wnx_in = next_ff[cs];
         end
         pbp_pkg::OP_WALK_ADV: begin
            cur_in   = wnx_ff;
            guard_in = guard_ff + IW'(1);
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_act_in    = out_act_ff;
      out_file_in   = out_file_ff;
      out_page_in   = out_page_ff;
      out_last_in   = out_last_ff;
      if (ld_out) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.em.status;
         out_slot_in   = cmd.em.slot_en ? cur_ff[4:0] : 5'd0;
         out_act_in    = cmd.em.act;
         out_last_in   = cmd.em.last;
         case (cmd.em.src)
            pbp_pkg::SRC_TAG: begin
               out_file_in = tag_file_ff[cs];
               out_page_in = tag_page_ff[cs];
            end
            pbp_pkg::SRC_REQ: begin
               out_file_in = file_ff;
               out_page_in = page_ff;
            end
            default: begin
               out_file_in = 16'd0;
               out_page_in = 24'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_file_ff[i] <= 16'd0;
            tag_page_ff[i] <= 24'd0;
            res_ff[i]      <= 1'b0;
            dirty_ff[i]    <= 1'b0;
            pin_ff[i]      <= 8'd0;
            prev_ff[i]     <= (i == 0) ? NONE : IW'(i - 1);
            next_ff[i]     <= (i == NUM_SLOTS - 1) ? NONE : IW'(i + 1);
         end
      end else begin
         if (nx_we) next_ff[nx_wa] <= nx_wd;
         if (pv_we) prev_ff[pv_wa] <= pv_wd;
         case (cmd.op)
            pbp_pkg::OP_PIN_INC: begin
               if (pin_ff[cs] != 8'hFF) pin_ff[cs] <= pin_ff[cs] + 8'd1;
            end
            pbp_pkg::OP_PIN_DEC: pin_ff[cs] <= pin_ff[cs] - 8'd1;
            pbp_pkg::OP_SET_DIRTY: dirty_ff[cs] <= 1'b1;
            pbp_pkg::OP_CLR_DIRTY: dirty_ff[cs] <= 1'b0;
            pbp_pkg::OP_EVICT: begin
               dirty_ff[cs] <= 1'b0;
               res_ff[cs]   <= 1'b0;
            end
            pbp_pkg::OP_FILL: begin
               tag_file_ff[cs] <= file_ff;
               tag_page_ff[cs] <= page_ff;
               res_ff[cs]      <= 1'b1;
               dirty_ff[cs]    <= 1'b0;
               pin_ff[cs]      <= 8'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NONE;
         tail_ff      <= NONE;
         free_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff       <= kind_in;
      file_ff       <= file_in;
      page_ff       <= page_in;
      multi_ff      <= multi_in;
      hit_ff        <= hit_in;
      cur_ff        <= cur_in;
      pv_ff         <= pv_in;
      nx_ff         <= nx_in;
      wnx_ff        <= wnx_in;
      guard_ff      <= guard_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_act_ff    <= out_act_in;
      out_file_ff   <= out_file_in;
      out_page_ff   <= out_page_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_slot_index  = out_slot_ff;
   assign rsp_host_action = out_act_ff;
   assign rsp_action_file = out_file_ff;
   assign rsp_action_page = out_page_ff;
   assign rsp_last_result = out_last_ff;

   a_fill_pins: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pbp_pkg::OP_FILL |=> res_ff[$past(cs)] && pin_ff[$past(cs)] == 8'd1)
      else $error("filled slot not resident and singly pinned");

   a_link_head: assert property (@(posedge clock) disable iff (reset)
      cmd.op == pbp_pkg::OP_L2 |=> head_ff == $past(cur_ff))
      else $error("head not updated on link");

   a_wb_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_act_ff != pbp_pkg::ACT_NONE |-> out_status_ff == pbp_pkg::ST_OK)
      else $error("host action on error result");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      ld_out && cmd.em.slot_en |-> ok_idx(cur_ff))
      else $error("result names an invalid slot");

endmodule

### design/page_buffer_pool_lru_top.sv
// Top level of the page buffer pool slot manager (LRU replacement, pinning).
//
// Requests arrive on the req_ channel (valid/stall); a beat is taken when
// req_valid is high and req_stall low. Each request gives one or more result
// beats on the rsp_ channel, the final one flagged by rsp_last_result.
// One request is in work at a time: req_stall is high from acceptance until
// the final result has been loaded into the output register, which may still
// be waiting on the receiver when the next request is taken.
// Sequence: after acceptance a lookup state looks the tag up over all slots
// and a dispatch state follows. Errors, flush page, unknown kinds and an
// unpin that leaves the page pinned give their result straight from
// dispatch. A get hit, mark dirty or an unpin that drops the count to zero
// relinks in 4 steps. A free-list miss links in 2 steps and tags the slot.
// With no free slot the miss walks the recency list from the tail, a slot a
// cycle (up to NUM_SLOTS), then evicts, relinks and tags. Flush file and
// clear walk the list from the head, with a write-back beat for each dirty
// slot that flush file frees. A stalled receiver holds rsp_ beats in the
// output register and the sequencer waits at each result until free.
// Reset (synchronous) empties the pool: all slots free, nothing resident or
// pinned; requests are taken from the next cycle.
module page_buffer_pool_lru_top #(
   parameter int NUM_SLOTS = pbp_pkg::DEF_NUM_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_file_id,
   input  logic [23:0] req_page_number,
   input  logic        req_allow_multi_pin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_slot_index,
   output logic [1:0]  rsp_host_action,
   output logic [15:0] rsp_action_file,
   output logic [23:0] rsp_action_page,
   output logic        rsp_last_result
);

   pbp_pkg::cmd_type  cmd;
   pbp_pkg::stat_type stat;

   // sequencer: decides each step from the datapath status
   pbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot tables, list pointers and result register
   pbp_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_file_id         (req_file_id),
      .req_page_number     (req_page_number),
      .req_allow_multi_pin (req_allow_multi_pin),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_host_action     (rsp_host_action),
      .rsp_action_file     (rsp_action_file),
      .rsp_action_page     (rsp_action_page),
      .rsp_last_result     (rsp_last_result)
   );

endmodule
